@@ rtl/tdee_pkg.sv @@
// Shared widths, field layout, controller states and helper functions of the entropy estimator.
`default_nettype none

package tdee_pkg;

    localparam int unsigned DUR_W    = 48;
    localparam int unsigned BLK_W    = 14;
    localparam int unsigned TC_W     = 6;
    localparam int unsigned CREDIT_W = 7;
    localparam int unsigned BPB_W    = 5;
    localparam int unsigned TDATA_W  = 64;

    localparam logic [BPB_W-1:0] BPB_RESET = 5'd15;

    // Input tdata layout, lowest bit first
    localparam int unsigned IN_DUR_LSB = 0;
    localparam int unsigned IN_BLK_LSB = IN_DUR_LSB + DUR_W;
    localparam int unsigned IN_PAR_LSB = IN_BLK_LSB + BLK_W;

    // Output tdata layout, lowest bit first
    localparam int unsigned OUT_MIN_LSB = 0;
    localparam int unsigned OUT_TC_LSB  = OUT_MIN_LSB + DUR_W;
    localparam int unsigned OUT_CHG_LSB = OUT_TC_LSB + TC_W;
    localparam int unsigned OUT_CRD_LSB = OUT_CHG_LSB + 1;
    localparam int unsigned OUT_USED_W  = OUT_CRD_LSB + CREDIT_W;

    typedef logic [DUR_W-1:0] dur_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } ctrl_state_t;

    // Absolute difference of two durations
    function automatic dur_t abs_diff(input dur_t a, input dur_t b);
        dur_t r;
        if (a > b) begin
            r = a - b;
        end else begin
            r = b - a;
        end
        return r;
    endfunction

    function automatic dur_t min2(input dur_t a, input dur_t b);
        dur_t r;
        r = (a > b) ? b : a;
        return r;
    endfunction

    // Position of the highest set bit; zero for 0 and 1
    function automatic logic [TC_W-1:0] floor_log2(input dur_t v);
        logic [TC_W-1:0] r;
        r = '0;
        for (int i = 0; i < DUR_W; i++) begin
            if (v[i]) begin
                r = TC_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/timing_delta_entropy_estimator.sv @@
// Top level of the timing-delta entropy estimator: delta pipeline and parity vector memory.
`default_nettype none

// Timing-delta entropy estimator. Each request on the s_axis side carries one
// measurement (duration, block index, block parity bit) and yields exactly one
// request on the m_axis side, in order. The block forms the absolute first,
// second and third order deltas of the durations, takes the least of them
// (min_delta) and its floor log2 (time_credit, zero below two). A one-bit-per-
// block parity vector, held in a single-port-write / registered-read memory of
// NUM_BLOCKS entries, is tested and set; a changed bit adds twice
// bits_per_block to the credit. Block indices wrap modulo NUM_BLOCKS.
// Throughput is one measurement per clock once the clear pass is over, while
// m_axis does not stall; from acceptance a result passes S1 to S5 and the
// output register before it appears on m_axis. The rate is set by the parity
// memory read-modify-write, which is kept at one per cycle by forwarding the
// bit being written into a read of the same entry. After reset the memory is
// cleared one entry a cycle, in index order, during which s_axis_tready stays low;
// bits_per_block may be written at any time but is meant to be changed only
// while the block is idle. A stalled m_axis holds the whole pipeline.
module timing_delta_entropy_estimator
    import tdee_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 16384
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    // Configuration: bits_per_block
    input  wire                 cfg_wr_en,
    input  wire [BPB_W-1:0]     cfg_wr_data,
    // Measurements in
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: duration [47:0], block_index [61:48], parity_bit [62], zero [63]
    input  wire [TDATA_W-1:0]   s_axis_tdata,
    // Results out
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // tdata: min_delta [47:0], time_credit [53:48], parity_changed [54],
    //        credit [61:55], zero [63:62]
    output logic [TDATA_W-1:0]  m_axis_tdata
);

    localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    // Reciprocal for the modulo: exact for 14-bit indices at any depth from 2 to below 2**18
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_BLOCKS + 64'd1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    // ------------------------------------------------------------------
    // Control: clear pass, configuration register
    // ------------------------------------------------------------------
    ctrl_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [BPB_W-1:0]  bpb_reg;
    logic              adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next   = ST_RUN;
                    clr_cnt_next = '0;
                end
            end
            ST_RUN: begin
                clr_cnt_next = '0;
            end
            default: begin
                state_next   = ST_CLEAR;
                clr_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpb_reg <= BPB_RESET;
        end else if (cfg_wr_en) begin
            bpb_reg <= cfg_wr_data;
        end
    end

    // The whole pipeline moves when the output register is free
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv && (state_reg == ST_RUN);

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    // S1: accepted request
    logic              v1_reg;
    dur_t              dur1_reg;
    logic [BLK_W-1:0]  blk1_reg;
    logic              par1_reg;
    // S2: first delta, quotient for the index wrap
    logic              v2_reg;
    dur_t              d1_2_reg;
    logic [BLK_W-1:0]  q2_reg;
    logic [BLK_W-1:0]  blk2_reg;
    logic              par2_reg;
    // S3: second delta, wrapped index, memory read issued
    logic              v3_reg;
    dur_t              d1_3_reg;
    dur_t              d2_3_reg;
    logic [IDX_W-1:0]  idx3_reg;
    logic              par3_reg;
    // S4: third delta, memory data back, parity test and write
    logic              v4_reg;
    dur_t              m12_4_reg;
    dur_t              d3_4_reg;
    logic [IDX_W-1:0]  idx4_reg;
    logic              par4_reg;
    logic              rd_bit_reg;
    logic              fwd_hit_reg;
    logic              fwd_bit_reg;
    // S5: least delta and change flag
    logic              v5_reg;
    dur_t              m5_reg;
    logic              chg5_reg;
    // Output register
    dur_t              out_min_reg;
    logic [TC_W-1:0]   out_tc_reg;
    logic              out_chg_reg;
    logic [CREDIT_W-1:0] out_crd_reg;
    logic              out_valid_reg;

    // Delta history
    dur_t              prev_dur_reg;
    dur_t              prev_d1_reg;
    dur_t              prev_d2_reg;

    // ------------------------------------------------------------------
    // Stage logic
    // ------------------------------------------------------------------
    logic              v1_next;
    logic [45:0]       q_prod;
    logic [BLK_W-1:0]  q_next;
    dur_t              d1_next;
    dur_t              d2_next;
    logic [31:0]       qn_prod;
    logic [31:0]       rem_full;
    logic [IDX_W-1:0]  idx_next;
    dur_t              d3_next;
    dur_t              m12_next;
    logic              fwd_hit_next;
    logic              stored_bit;
    logic              chg_next;
    dur_t              m_next;
    logic [TC_W-1:0]   tc_next;
    logic [CREDIT_W-1:0] bonus;
    logic [CREDIT_W-1:0] crd_next;

    assign v1_next = s_axis_tvalid && s_axis_tready;

    // S1 -> S2
    assign d1_next = abs_diff(dur1_reg, prev_dur_reg);
    assign q_prod  = 46'(blk1_reg) * 46'(RECIP);
    assign q_next  = q_prod[45:32];

    // S2 -> S3
    assign d2_next  = abs_diff(d1_2_reg, prev_d1_reg);
    assign qn_prod  = 32'(q2_reg) * 32'(NUM_BLOCKS);
    assign rem_full = 32'(blk2_reg) - qn_prod;
    assign idx_next = rem_full[IDX_W-1:0];

    // S3 -> S4: forward the bit that S4 writes on this edge into the read
    assign d3_next      = abs_diff(d2_3_reg, prev_d2_reg);
    assign m12_next     = min2(d1_3_reg, d2_3_reg);
    assign fwd_hit_next = v4_reg && (idx4_reg == idx3_reg);

    // S4 -> S5
    assign stored_bit = fwd_hit_reg ? fwd_bit_reg : rd_bit_reg;
    assign chg_next   = stored_bit != par4_reg;
    assign m_next     = min2(m12_4_reg, d3_4_reg);

    // S5 -> output
    assign tc_next  = floor_log2(m5_reg);
    assign bonus    = chg5_reg ? {1'b0, bpb_reg, 1'b0} : '0;
    assign crd_next = CREDIT_W'(tc_next) + bonus;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_dur_reg  <= '0;
            prev_d1_reg   <= '0;
            prev_d2_reg   <= '0;
        end else if (adv) begin
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
            // Advance the delta history only with real requests
            if (v1_reg) begin
                prev_dur_reg <= dur1_reg;
            end
            if (v2_reg) begin
                prev_d1_reg <= d1_2_reg;
            end
            if (v3_reg) begin
                prev_d2_reg <= d2_3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dur1_reg    <= s_axis_tdata[IN_DUR_LSB +: DUR_W];
            blk1_reg    <= s_axis_tdata[IN_BLK_LSB +: BLK_W];
            par1_reg    <= s_axis_tdata[IN_PAR_LSB];

            d1_2_reg    <= d1_next;
            q2_reg      <= q_next;
            blk2_reg    <= blk1_reg;
            par2_reg    <= par1_reg;

            d1_3_reg    <= d1_2_reg;
            d2_3_reg    <= d2_next;
            idx3_reg    <= idx_next;
            par3_reg    <= par2_reg;

            m12_4_reg   <= m12_next;
            d3_4_reg    <= d3_next;
            idx4_reg    <= idx3_reg;
            par4_reg    <= par3_reg;
            fwd_hit_reg <= fwd_hit_next;
            fwd_bit_reg <= par4_reg;

            m5_reg      <= m_next;
            chg5_reg    <= chg_next;

            out_min_reg <= m5_reg;
            out_tc_reg  <= tc_next;
            out_chg_reg <= chg5_reg;
            out_crd_reg <= crd_next;
        end
    end

    // ------------------------------------------------------------------
    // Parity vector memory: registered read, one write a cycle
    // ------------------------------------------------------------------
    logic              mem [NUM_BLOCKS];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic              mem_wdata;

    // After the test the entry always holds the request's parity bit
    assign mem_we    = (state_reg == ST_CLEAR) || (v4_reg && adv);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx4_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? 1'b0 : par4_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (adv) begin
            rd_bit_reg <= mem[idx3_reg];
        end
    end

    // ------------------------------------------------------------------
    // Output
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - OUT_USED_W){1'b0}},
                            out_crd_reg, out_chg_reg, out_tc_reg, out_min_reg};

endmodule

`default_nettype wire
